@@ hdl/midpoint_circle_points_assert.svh @@
// Assertion macros for the midpoint circle rasteriser.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef MIDPOINT_CIRCLE_POINTS_ASSERT_SVH
`define MIDPOINT_CIRCLE_POINTS_ASSERT_SVH
`ifndef ASSERT_OFF
// Plain property, checked on every clock edge outside reset
`define MCP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Implication, checked on every clock edge outside reset
`define MCP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
`else
`define MCP_ASSERT(lbl, clk, rst_n, prop, msg)
`define MCP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ hdl/mcp_pkg.sv @@
// Shared constants for the midpoint circle rasteriser.
// Used by mcp_front, mcp_cmd_fifo, mcp_back and midpoint_circle_points.
`default_nettype none

package mcp_pkg;

    // Default coordinate width and fixed register widths
    localparam int COORD_WIDTH_DEF  = 11;
    localparam int RADIUS_WIDTH     = 10;
    localparam int CFG_INDEX_WIDTH  = 2;
    localparam int CFG_DATA_WIDTH   = 16;

    // Configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CENTER_X = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RADIUS   = 2'd2;

    // Command kinds passed from front to back
    localparam int CMD_KIND_WIDTH = 2;
    localparam logic [CMD_KIND_WIDTH-1:0] CMD_RESTART = 2'd0;
    localparam logic [CMD_KIND_WIDTH-1:0] CMD_STEP    = 2'd1;
    localparam logic [CMD_KIND_WIDTH-1:0] CMD_DONE    = 2'd2;

    // Command queue depth
    localparam int CMD_DEPTH = 2;

    // Result sequencing within one command
    localparam int IDX_WIDTH    = 4;
    localparam int MIRROR_WIDTH = 3;
    localparam logic [IDX_WIDTH-1:0] LAST_IDX_RESTART = 4'd8;
    localparam logic [IDX_WIDTH-1:0] LAST_IDX_STEP    = 4'd7;

endpackage

`default_nettype wire

@@ hdl/midpoint_circle_points.sv @@
// Top level of the midpoint circle rasteriser: front end, command queue, back end.
// Depends on mcp_pkg, mcp_front, mcp_cmd_fifo and mcp_back.
`default_nettype none

// Midpoint circle rasteriser. Write center_x, center_y and radius on the cfg
// channel (always ready) while idle, then push items: restart=1 starts a circle
// and yields nine results (centre, then the eight mirrored points of (0, r));
// restart=0 yields eight mirrored points of the next offset, or one done result
// once the octant is finished or no circle is active. The front end updates the
// octant state in the cycle an item is transferred and queues a command in a
// two-entry queue; the back end sends one result per cycle, while the receiver pops,
// through a single output register. Sustained rate is therefore set by that output
// register and the number of results per command. Each result passes through the
// queue and the output register. Points are two's complement, COORD_WIDTH+2 bits.
module midpoint_circle_points import mcp_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic                          i_restart,
    output logic                               empty,
    input  wire logic                          pop,
    output logic signed [COORD_WIDTH+1:0]      o_point_x,
    output logic signed [COORD_WIDTH+1:0]      o_point_y,
    output logic                               o_point_valid,
    output logic                               o_last_of_step,
    output logic                               o_circle_done,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [CFG_INDEX_WIDTH-1:0]    i_cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]     i_cfg_data
);

    localparam int CMD_WIDTH = CMD_KIND_WIDTH + 4 * COORD_WIDTH;

    logic                 w_cmd_push, w_cmd_full, w_cmd_pop, w_cmd_empty;
    logic [CMD_WIDTH-1:0] w_cmd_in, w_cmd_out;

    // Register writes never stall
    assign o_cfg_ready = 1'b1;

    mcp_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_restart   (i_restart),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_full  (w_cmd_full),
        .o_cmd_push  (w_cmd_push),
        .o_cmd       (w_cmd_in)
    );

    mcp_cmd_fifo #(
        .WIDTH (CMD_WIDTH),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_data  (w_cmd_in),
        .o_full  (w_cmd_full),
        .i_pop   (w_cmd_pop),
        .o_data  (w_cmd_out),
        .o_empty (w_cmd_empty)
    );

    mcp_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd_out),
        .i_cmd_empty    (w_cmd_empty),
        .o_cmd_pop      (w_cmd_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_point_x      (o_point_x),
        .o_point_y      (o_point_y),
        .o_point_valid  (o_point_valid),
        .o_last_of_step (o_last_of_step),
        .o_circle_done  (o_circle_done)
    );

    assign full = w_cmd_full;

endmodule

`default_nettype wire

@@ hdl/mcp_front.sv @@
// Front end: configuration registers, octant state and command classification.
// Depends on mcp_pkg; feeds commands into mcp_cmd_fifo.
`default_nettype none

module mcp_front import mcp_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_push,
    input  wire logic                                     i_restart,
    input  wire logic                                     i_cfg_valid,
    input  wire logic [CFG_INDEX_WIDTH-1:0]               i_cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]                i_cfg_data,
    input  wire logic                                     i_cmd_full,
    output logic                                          o_cmd_push,
    output logic [CMD_KIND_WIDTH+4*COORD_WIDTH-1:0]       o_cmd
);

    localparam int DW = COORD_WIDTH + 2;

    typedef struct packed {
        logic [CMD_KIND_WIDTH-1:0] kind;
        logic [COORD_WIDTH-1:0]    cx;
        logic [COORD_WIDTH-1:0]    cy;
        logic [COORD_WIDTH-1:0]    x;
        logic [COORD_WIDTH-1:0]    y;
    } t_cmd;

    logic [COORD_WIDTH-1:0]  r_center_x, r_center_y;
    logic [RADIUS_WIDTH-1:0] r_radius;
    logic [COORD_WIDTH-1:0]  r_off_x, r_off_y, n_off_x, n_off_y;
    logic [DW-1:0]           r_dec, n_dec;
    logic                    r_drawing, n_drawing;

    logic                    w_accept;
    logic                    w_finished;
    logic [COORD_WIDTH-1:0]  w_x_inc, w_y_new;
    logic [DW-1:0]           w_term, w_dec_new;
    t_cmd                    w_cmd;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_radius   <= RADIUS_WIDTH'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CENTER_X: r_center_x <= COORD_WIDTH'(i_cfg_data);
                CFG_CENTER_Y: r_center_y <= COORD_WIDTH'(i_cfg_data);
                CFG_RADIUS:   r_radius   <= RADIUS_WIDTH'(i_cfg_data);
                default: ;
            endcase
        end
    end

    assign w_accept = i_push & ~i_cmd_full;

    // Midpoint step: x advances, y drops when the decision is not negative
    assign w_finished = !r_drawing || (r_off_x > r_off_y);
    assign w_x_inc    = r_off_x + COORD_WIDTH'(1);
    assign w_y_new    = (r_dec[DW-1] || (r_off_y == '0)) ? r_off_y
                                                          : r_off_y - COORD_WIDTH'(1);
    assign w_term     = r_dec[DW-1] ? DW'(w_x_inc) : DW'(w_x_inc) - DW'(w_y_new);
    assign w_dec_new  = r_dec + {w_term[DW-2:0], 1'b0} + DW'(1);

    // Next state and command
    always_comb begin
        n_off_x   = r_off_x;
        n_off_y   = r_off_y;
        n_dec     = r_dec;
        n_drawing = r_drawing;
        w_cmd.cx  = r_center_x;
        w_cmd.cy  = r_center_y;
        if (i_restart) begin
            n_off_x    = '0;
            n_off_y    = COORD_WIDTH'(r_radius);
            n_dec      = DW'(1) - DW'(r_radius);
            n_drawing  = 1'b1;
            w_cmd.kind = CMD_RESTART;
            w_cmd.x    = '0;
            w_cmd.y    = COORD_WIDTH'(r_radius);
        end else if (w_finished) begin
            n_drawing  = 1'b0;
            w_cmd.kind = CMD_DONE;
            w_cmd.x    = '0;
            w_cmd.y    = '0;
        end else begin
            n_off_x    = w_x_inc;
            n_off_y    = w_y_new;
            n_dec      = w_dec_new;
            w_cmd.kind = CMD_STEP;
            w_cmd.x    = w_x_inc;
            w_cmd.y    = w_y_new;
        end
    end

    // Octant state, updated on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_x   <= '0;
            r_off_y   <= '0;
            r_dec     <= '0;
            r_drawing <= 1'b0;
        end else if (w_accept) begin
            r_off_x   <= n_off_x;
            r_off_y   <= n_off_y;
            r_dec     <= n_dec;
            r_drawing <= n_drawing;
        end
    end

    assign o_cmd_push = w_accept;
    assign o_cmd      = w_cmd;

endmodule

`default_nettype wire

@@ hdl/mcp_cmd_fifo.sv @@
// Short command queue between the front and back ends.
// Depends on mcp_pkg for its default width and depth.
`default_nettype none

module mcp_cmd_fifo import mcp_pkg::*; #(
    parameter int WIDTH = CMD_KIND_WIDTH + 4 * COORD_WIDTH_DEF,
    parameter int DEPTH = CMD_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

`include "midpoint_circle_points_assert.svh"

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;

    // Storage; no reset needed on data
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);

    // Checks
    `MCP_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, i_push, !o_full || i_pop, "push into full queue")
    `MCP_ASSERT_IMPL(a_no_underflow, i_clk, i_rst_n, i_pop, !o_empty, "pop from empty queue")
    `MCP_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH), "fill count past depth")

endmodule

`default_nettype wire

@@ hdl/mcp_back.sv @@
// Back end: expands each command into its results through a one-entry output register.
// Depends on mcp_pkg; reads commands from mcp_cmd_fifo.
`default_nettype none

module mcp_back import mcp_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic [CMD_KIND_WIDTH+4*COORD_WIDTH-1:0] i_cmd,
    input  wire logic                                i_cmd_empty,
    output logic                                     o_cmd_pop,
    input  wire logic                                i_pop,
    output logic                                     o_empty,
    output logic signed [COORD_WIDTH+1:0]            o_point_x,
    output logic signed [COORD_WIDTH+1:0]            o_point_y,
    output logic                                     o_point_valid,
    output logic                                     o_last_of_step,
    output logic                                     o_circle_done
);

`include "midpoint_circle_points_assert.svh"

    localparam int PW = COORD_WIDTH + 2;

    typedef struct packed {
        logic [CMD_KIND_WIDTH-1:0] kind;
        logic [COORD_WIDTH-1:0]    cx;
        logic [COORD_WIDTH-1:0]    cy;
        logic [COORD_WIDTH-1:0]    x;
        logic [COORD_WIDTH-1:0]    y;
    } t_cmd;

    t_cmd                   w_cmd;
    logic                   w_load;
    logic [MIRROR_WIDTH-1:0] w_mirror;
    logic                   w_swap, w_neg_x, w_neg_y;
    logic [COORD_WIDTH-1:0] w_mag_x, w_mag_y;
    logic [PW-1:0]          n_px, n_py;
    logic                   n_valid, n_last, n_done;

    logic [IDX_WIDTH-1:0]   r_idx;
    logic                   r_out_valid;
    logic [PW-1:0]          r_px, r_py;
    logic                   r_valid, r_last, r_done;

    assign w_cmd  = t_cmd'(i_cmd);
    assign w_load = !i_cmd_empty && (!r_out_valid || i_pop);

    // Mirror number; a restart spends its first result on the centre
    assign w_mirror = (w_cmd.kind == CMD_RESTART) ? MIRROR_WIDTH'(r_idx - IDX_WIDTH'(1))
                                                  : MIRROR_WIDTH'(r_idx);

    // Octant mirror decoder: swap x/y and sign of each axis
    always_comb begin
        unique case (w_mirror)
            3'd0: begin w_swap = 1'b0; w_neg_x = 1'b0; w_neg_y = 1'b0; end
            3'd1: begin w_swap = 1'b1; w_neg_x = 1'b0; w_neg_y = 1'b0; end
            3'd2: begin w_swap = 1'b1; w_neg_x = 1'b0; w_neg_y = 1'b1; end
            3'd3: begin w_swap = 1'b0; w_neg_x = 1'b0; w_neg_y = 1'b1; end
            3'd4: begin w_swap = 1'b0; w_neg_x = 1'b1; w_neg_y = 1'b1; end
            3'd5: begin w_swap = 1'b1; w_neg_x = 1'b1; w_neg_y = 1'b1; end
            3'd6: begin w_swap = 1'b1; w_neg_x = 1'b1; w_neg_y = 1'b0; end
            default: begin w_swap = 1'b0; w_neg_x = 1'b1; w_neg_y = 1'b0; end
        endcase
    end

    assign w_mag_x = w_swap ? w_cmd.y : w_cmd.x;
    assign w_mag_y = w_swap ? w_cmd.x : w_cmd.y;

    // Result for the current index
    always_comb begin
        n_valid = 1'b1;
        n_done  = 1'b0;
        n_last  = 1'b0;
        n_px    = w_neg_x ? PW'(w_cmd.cx) - PW'(w_mag_x) : PW'(w_cmd.cx) + PW'(w_mag_x);
        n_py    = w_neg_y ? PW'(w_cmd.cy) - PW'(w_mag_y) : PW'(w_cmd.cy) + PW'(w_mag_y);
        unique case (w_cmd.kind)
            CMD_RESTART: begin
                n_last = (r_idx == LAST_IDX_RESTART);
                if (r_idx == '0) begin
                    n_px = PW'(w_cmd.cx);
                    n_py = PW'(w_cmd.cy);
                end
            end
            CMD_STEP: begin
                n_last = (r_idx == LAST_IDX_STEP);
            end
            default: begin
                // octant finished or no circle active: a single result with no point
                n_valid = 1'b0;
                n_done  = 1'b1;
                n_last  = 1'b1;
                n_px    = '0;
                n_py    = '0;
            end
        endcase
    end

    // Sequencer and output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
            r_idx       <= n_last ? '0 : r_idx + IDX_WIDTH'(1);
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_px    <= n_px;
            r_py    <= n_py;
            r_valid <= n_valid;
            r_last  <= n_last;
            r_done  <= n_done;
        end
    end

    assign o_cmd_pop      = w_load & n_last;
    assign o_empty        = !r_out_valid;
    assign o_point_x      = r_px;
    assign o_point_y      = r_py;
    assign o_point_valid  = r_valid;
    assign o_last_of_step = r_last;
    assign o_circle_done  = r_done;

    // Checks
    `MCP_ASSERT(a_idx_range, i_clk, i_rst_n, r_idx <= LAST_IDX_RESTART, "result index past nine")
    `MCP_ASSERT_IMPL(a_step_len, i_clk, i_rst_n, w_load && (w_cmd.kind == CMD_STEP), r_idx <= LAST_IDX_STEP, "step command past eight results")
    `MCP_ASSERT_IMPL(a_done_shape, i_clk, i_rst_n, r_out_valid && r_done, !r_valid && r_last, "done result carries a point")

endmodule

`default_nettype wire

@@ tb/midpoint_circle_points_tb.sv @@
// Self-checking testbench for the midpoint circle rasteriser top level.
// Depends on mcp_pkg and midpoint_circle_points; predicts every point in SystemVerilog.
`default_nettype none

module midpoint_circle_points_tb;
    import mcp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW          = COORD_WIDTH_DEF;
    localparam int PW          = CW + 2;
    localparam int CYCLE_LIMIT = 300000;
    localparam int LONG_HOLD   = 300;
    localparam int END_WAIT    = 32;
    localparam int RANDOM_END  = 400;
    localparam int QUIET_TAIL  = 70;
    localparam int PRINT_CAP   = 200;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UNUSED = 2'd3;

    // One expected point (or done marker) as the block presents it
    typedef struct packed {
        logic [PW-1:0] px;
        logic [PW-1:0] py;
        logic          valid;
        logic          last;
        logic          done;
    } t_circle_point;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          push;
    logic                          full;
    logic                          i_restart;
    logic                          empty;
    logic                          pop;
    logic signed [PW-1:0]          o_point_x;
    logic signed [PW-1:0]          o_point_y;
    logic                          o_point_valid;
    logic                          o_last_of_step;
    logic                          o_circle_done;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0]    i_cfg_index;
    logic [CFG_DATA_WIDTH-1:0]     i_cfg_data;

    // Shadow copy of registers and octant state
    logic [CW-1:0]           cfg_cx;
    logic [CW-1:0]           cfg_cy;
    logic [RADIUS_WIDTH-1:0] cfg_radius;
    logic [CW-1:0]           off_x;
    logic [CW-1:0]           off_y;
    logic signed [PW-1:0]    decision;
    logic                    pen_down;

    t_circle_point expected_points[$];
    int  mismatches     = 0;
    int  items_sent     = 0;
    int  cycle_count    = 0;
    bit  sender_gaps    = 1'b0;
    bit  receiver_stall = 1'b0;
    bit  long_hold_req  = 1'b0;

    midpoint_circle_points #(.COORD_WIDTH(CW)) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_restart      (i_restart),
        .empty          (empty),
        .pop            (pop),
        .o_point_x      (o_point_x),
        .o_point_y      (o_point_y),
        .o_point_valid  (o_point_valid),
        .o_last_of_step (o_last_of_step),
        .o_circle_done  (o_circle_done),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // 8 ns clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Cycle counter and watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("midpoint_circle_points: mismatch");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        // printing is capped to keep a broken run's log readable
        if (mismatches < PRINT_CAP)
            $display("ERROR cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    function automatic t_circle_point make_point(input int px, input int py,
                                                 input logic valid, input logic last,
                                                 input logic done);
        t_circle_point p;
        p.px    = PW'(px);
        p.py    = PW'(py);
        p.valid = valid;
        p.last  = last;
        p.done  = done;
        return p;
    endfunction

    // Eight mirrored points of the current offset, last one flagged
    task automatic queue_octants();
        int cx, cy, x, y;
        cx = int'(cfg_cx);
        cy = int'(cfg_cy);
        x  = int'(off_x);
        y  = int'(off_y);
        expected_points.push_back(make_point(cx + x, cy + y, 1'b1, 1'b0, 1'b0));
        expected_points.push_back(make_point(cx + y, cy + x, 1'b1, 1'b0, 1'b0));
        expected_points.push_back(make_point(cx + y, cy - x, 1'b1, 1'b0, 1'b0));
        expected_points.push_back(make_point(cx + x, cy - y, 1'b1, 1'b0, 1'b0));
        expected_points.push_back(make_point(cx - x, cy - y, 1'b1, 1'b0, 1'b0));
        expected_points.push_back(make_point(cx - y, cy - x, 1'b1, 1'b0, 1'b0));
        expected_points.push_back(make_point(cx - y, cy + x, 1'b1, 1'b0, 1'b0));
        expected_points.push_back(make_point(cx - x, cy + y, 1'b1, 1'b1, 1'b0));
    endtask

    // Midpoint rasteriser step: updates shadow state, queues resulting points
    task automatic rasterise_step(input logic restart);
        if (restart) begin
            off_x    = '0;
            off_y    = CW'(cfg_radius);
            decision = PW'(1 - int'(cfg_radius));
            pen_down = 1'b1;
            expected_points.push_back(make_point(int'(cfg_cx), int'(cfg_cy),
                                                 1'b1, 1'b0, 1'b0));
            queue_octants();
        end else if (!pen_down || off_x > off_y) begin
            // octant finished, or no circle active
            pen_down = 1'b0;
            expected_points.push_back(make_point(0, 0, 1'b0, 1'b1, 1'b1));
        end else begin
            off_x = off_x + 1'b1;
            if (decision < 0) begin
                decision = PW'(int'(decision) + 2 * int'(off_x) + 1);
            end else begin
                // y saturates at zero for a zero radius
                if (off_y > 0)
                    off_y = off_y - 1'b1;
                decision = PW'(int'(decision) + 2 * (int'(off_x) - int'(off_y)) + 1);
            end
            queue_octants();
        end
    endtask

    // Offer one item and hold it until the transfer; optional idle burst after
    task automatic send_item(input logic restart);
        push      <= 1'b1;
        i_restart <= restart;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        rasterise_step(restart);
        items_sent++;
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            push      <= 1'b0;
            i_restart <= 1'($urandom_range(0, 1));
            repeat ($urandom_range(1, 5))
                @(posedge i_clk);
        end
    endtask

    task automatic wait_for_results();
        push <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge i_clk);
    endtask

    // Write all registers (plus the unused index) once the block is idle
    task automatic configure(input int cx, input int cy, input int r);
        logic [CFG_DATA_WIDTH-1:0] word [4];
        for (int i = 0; i < 4; i++)
            word[i] = CFG_DATA_WIDTH'($urandom);
        word[CFG_CENTER_X][CW-1:0]         = CW'(cx);
        word[CFG_CENTER_Y][CW-1:0]         = CW'(cy);
        word[CFG_RADIUS][RADIUS_WIDTH-1:0] = RADIUS_WIDTH'(r);
        wait_for_results();
        for (int i = 0; i < 4; i++) begin
            i_cfg_index <= CFG_INDEX_WIDTH'(i);
            i_cfg_data  <= word[i];
            i_cfg_valid <= 1'b1;
            @(posedge i_clk);
            while (!o_cfg_ready)
                @(posedge i_clk);
            case (CFG_INDEX_WIDTH'(i))
                CFG_CENTER_X: cfg_cx     = word[i][CW-1:0];
                CFG_CENTER_Y: cfg_cy     = word[i][CW-1:0];
                CFG_RADIUS:   cfg_radius = word[i][RADIUS_WIDTH-1:0];
                CFG_UNUSED:   ;
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Steps before any circle and after one has finished, reset register values
    task automatic test_idle_steps();
        send_item(1'b0);
        send_item(1'b0);
        send_item(1'b1);
        repeat (3)
            send_item(1'b0);
    endtask

    // Coordinate and radius extremes, including negative points
    task automatic test_extremes();
        configure(2047, 2047, 1023);
        send_item(1'b1);
        send_item(1'b0);
        send_item(1'b0);
        configure(0, 0, 1023);
        send_item(1'b1);
        send_item(1'b0);
        send_item(1'b0);
        configure(2047, 0, 1);
        send_item(1'b1);
        send_item(1'b0);
        send_item(1'b0);
    endtask

    // Zero radius: all restart points on the centre, then y saturates
    task automatic test_zero_radius();
        configure(1000, 37, 0);
        send_item(1'b1);
        repeat (3)
            send_item(1'b0);
    endtask

    // Receiver holds off while the sender keeps offering, then a full drain
    task automatic test_backpressure();
        configure($urandom_range(0, 2047), $urandom_range(0, 2047), 20);
        long_hold_req = 1'b1;
        send_item(1'b1);
        repeat (15)
            send_item(1'b0);
        wait_for_results();
    endtask

    // One circle: mostly run to done, sometimes cut short by a new restart
    task automatic draw_circle(input int step_cap);
        int steps;
        steps = 0;
        send_item(1'b1);
        while (pen_down && steps < step_cap) begin
            if ($urandom_range(0, 99) < 4)
                return;
            send_item(1'b0);
            steps++;
        end
        repeat ($urandom_range(0, 2))
            send_item(1'b0);
    endtask

    task automatic test_random_circles();
        int cx, cy, r, pick, cap;
        while (items_sent < RANDOM_END) begin
            if (items_sent > RANDOM_END - QUIET_TAIL) begin
                sender_gaps    = 1'b0;
                receiver_stall = 1'b0;
            end
            cx   = $urandom_range(0, 2047);
            cy   = $urandom_range(0, 2047);
            pick = $urandom_range(0, 99);
            cap  = 1000;
            if (pick < 70) begin
                r = $urandom_range(1, 24);
            end else if (pick < 88) begin
                r = $urandom_range(25, 80);
            end else if (pick < 95) begin
                r = $urandom_range(0, 1);
                cx = ($urandom_range(0, 1) != 0) ? 2047 : 0;
                cy = ($urandom_range(0, 1) != 0) ? 2047 : 0;
            end else begin
                // large radius: only the first part of the octant
                r   = 1023 - $urandom_range(0, 3);
                cap = 12;
            end
            configure(cx, cy, r);
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(0, 19) == 0)
                    send_item(1'($urandom_range(0, 1)));
                draw_circle(cap);
            end
        end
    endtask

    // Result side: random pop bursts, plus a long hold-off on request
    initial begin
        pop <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                pop <= 1'b0;
                repeat (LONG_HOLD)
                    @(posedge i_clk);
            end else if (receiver_stall && $urandom_range(0, 3) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 5))
                    @(posedge i_clk);
            end else begin
                pop <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Compare every result transfer with the oldest expected point
    always @(posedge i_clk) begin
        t_circle_point want;
        if (i_rst_n && pop && !empty) begin
            if (expected_points.size() == 0) begin
                report_mismatch("result transfer with nothing expected");
            end else begin
                want = expected_points.pop_front();
                if (o_point_x !== want.px)
                    report_mismatch($sformatf("point_x got %0d want %0d",
                                              o_point_x, $signed(want.px)));
                if (o_point_y !== want.py)
                    report_mismatch($sformatf("point_y got %0d want %0d",
                                              o_point_y, $signed(want.py)));
                if (o_point_valid !== want.valid)
                    report_mismatch($sformatf("point_valid got %b want %b",
                                              o_point_valid, want.valid));
                if (o_last_of_step !== want.last)
                    report_mismatch($sformatf("last_of_step got %b want %b",
                                              o_last_of_step, want.last));
                if (o_circle_done !== want.done)
                    report_mismatch($sformatf("circle_done got %b want %b",
                                              o_circle_done, want.done));
            end
        end
    end

    // Test sequence
    initial begin
        i_rst_n     <= 1'b0;
        push        <= 1'b0;
        i_restart   <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_CENTER_X;
        i_cfg_data  <= '0;
        cfg_cx      = '0;
        cfg_cy      = '0;
        cfg_radius  = RADIUS_WIDTH'(1);
        off_x       = '0;
        off_y       = '0;
        decision    = '0;
        pen_down    = 1'b0;
        repeat (11)
            @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_steps();
        test_extremes();
        test_zero_radius();
        sender_gaps    = 1'b1;
        receiver_stall = 1'b1;
        test_backpressure();
        test_random_circles();

        // drain, then watch for stray results
        wait_for_results();
        repeat (END_WAIT)
            @(posedge i_clk);
        if (expected_points.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_points.size()));
        if (mismatches == 0) begin
            $display("midpoint_circle_points: match");
        end else begin
            $display("midpoint_circle_points: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
